/* hdl/cdoq_pkg.sv */
// Shared constants, codes and state type for the coalescing drop-oldest queue.
package cdoq_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int DROP_W   = 16;
    localparam int FILL_W   = 7;

    localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KEYED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP   = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN_RD = 5'b00010,
        ST_SCAN_WR = 5'b00100,
        ST_APPEND  = 5'b01000,
        ST_POP     = 5'b10000
    } t_state;

endpackage

/* hdl/coalescing_drop_oldest_queue.sv */
// A null push, an unused kind or a pop of an empty queue completes straight from idle; a pop
// goes through ST_POP, a plain push through ST_APPEND; a keyed push to a non-empty queue first
// runs the key-removal pass (ST_SCAN_RD, ST_SCAN_WR): it reads each of the N entries held at
// accept and rewrites the kept ones through the single entry memory port pair, then appends.
// busy is high while a transaction runs, falling as o_valid rises. o_valid is high for one cycle and
// the receiver cannot stall. Synchronous active-low reset empties the queue, clears the drop count.
module coalescing_drop_oldest_queue #(
    parameter int DEPTH       = cdoq_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = cdoq_pkg::HANDLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [cdoq_pkg::KIND_W-1:0]    i_kind,
    input  logic [cdoq_pkg::KEY_W-1:0]     i_key,
    input  logic [cdoq_pkg::HANDLE_W-1:0]  i_handle,
    output logic                           o_valid,
    output logic                           o_pop_valid,
    output logic [cdoq_pkg::HANDLE_W-1:0]  o_pop_handle,
    output logic                           o_evicted,
    output logic [cdoq_pkg::DROP_W-1:0]    o_drop_report,
    output logic [cdoq_pkg::FILL_W-1:0]    o_fill_level
);
    import cdoq_pkg::*;

    localparam int SW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef struct packed {
        logic              keyed;
        logic [KEY_W-1:0]  key;
        logic [SW-1:0]     handle;
    } t_entry;

    function automatic logic [PW-1:0] wrap(input logic [CW:0] s);
        logic [CW:0] d;
        d = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
        return d[PW-1:0];
    endfunction

    t_entry mem [DEPTH];
    t_entry r_rd_data;

    t_state r_state, n_state;
    logic [PW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic [CW-1:0]       r_wr_idx, n_wr_idx;
    logic [DROP_W-1:0]   r_drop, n_drop;
    logic                r_keyed, n_keyed;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [SW-1:0]       r_handle, n_handle;

    logic                r_done, n_done;
    logic                r_pop_valid, n_pop_valid;
    logic [HANDLE_W-1:0] r_pop_handle, n_pop_handle;
    logic                r_evicted, n_evicted;
    logic [DROP_W-1:0]   r_drop_report, n_drop_report;
    logic [FILL_W-1:0]   r_fill, n_fill;

    logic          we;
    logic [PW-1:0] waddr;
    t_entry        wdata;
    logic [PW-1:0] rd_addr;
    logic [SW-1:0] in_handle;
    logic          keep;
    logic          full;

    assign in_handle = i_handle[SW-1:0];
    assign keep      = !(r_rd_data.keyed && (r_rd_data.key == r_key));
    assign full      = (r_count == DEPTH_C);
    assign rd_addr   = wrap((CW + 1)'(r_head)
                            + (CW + 1)'((r_state == ST_SCAN_RD) ? r_rd_idx : '0));

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_count       = r_count;
        n_rd_idx      = r_rd_idx;
        n_wr_idx      = r_wr_idx;
        n_drop        = r_drop;
        n_keyed       = r_keyed;
        n_key         = r_key;
        n_handle      = r_handle;
        n_done        = 1'b0;
        n_pop_valid   = r_pop_valid;
        n_pop_handle  = r_pop_handle;
        n_evicted     = r_evicted;
        n_drop_report = r_drop_report;
        n_fill        = r_fill;
        we            = 1'b0;
        waddr         = wrap((CW + 1)'(r_head) + (CW + 1)'(r_wr_idx));
        wdata         = r_rd_data;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_keyed  = (i_kind == KIND_KEYED);
                    n_key    = i_key;
                    n_handle = in_handle;
                    n_rd_idx = '0;
                    n_wr_idx = '0;
                    case (i_kind) inside
                        KIND_PLAIN, KIND_KEYED: begin
                            if (in_handle != '0) begin
                                if ((i_kind == KIND_KEYED) && (r_count != '0)) begin
                                    n_state = ST_SCAN_RD;
                                end else begin
                                    n_state = ST_APPEND;
                                end
                            end else begin
                                n_done        = 1'b1;
                                n_pop_valid   = 1'b0;
                                n_pop_handle  = '0;
                                n_evicted     = 1'b0;
                                n_drop_report = '0;
                                n_fill        = FILL_W'(r_count);
                            end
                        end
                        KIND_POP: begin
                            if (r_count != '0) begin
                                n_state = ST_POP;
                            end else begin
                                n_done        = 1'b1;
                                n_pop_valid   = 1'b0;
                                n_pop_handle  = '0;
                                n_evicted     = 1'b0;
                                n_drop_report = r_drop;
                                n_drop        = '0;
                                n_fill        = FILL_W'(r_count);
                            end
                        end
                        default: begin
                            n_done        = 1'b1;
                            n_pop_valid   = 1'b0;
                            n_pop_handle  = '0;
                            n_evicted     = 1'b0;
                            n_drop_report = '0;
                            n_fill        = FILL_W'(r_count);
                        end
                    endcase
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_WR;
            end
            ST_SCAN_WR: begin
                if (keep) begin
                    we       = 1'b1;
                    n_wr_idx = r_wr_idx + 1'b1;
                end
                n_rd_idx = r_rd_idx + 1'b1;
                if ((r_rd_idx + 1'b1) == r_count) begin
                    n_count = keep ? (r_wr_idx + 1'b1) : r_wr_idx;
                    n_state = ST_APPEND;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_APPEND: begin
                we           = 1'b1;
                waddr        = wrap((CW + 1)'(r_head) + (CW + 1)'(r_count));
                wdata.keyed  = r_keyed;
                wdata.key    = r_keyed ? r_key : '0;
                wdata.handle = r_handle;
                n_done        = 1'b1;
                n_pop_valid   = 1'b0;
                n_pop_handle  = '0;
                n_drop_report = '0;
                n_evicted     = full;
                if (full) begin
                    n_head = wrap((CW + 1)'(r_head) + (CW + 1)'(1));
                    if (!(&r_drop)) begin
                        n_drop = r_drop + 1'b1;
                    end
                    n_fill = FILL_W'(r_count);
                end else begin
                    n_count = r_count + 1'b1;
                    n_fill  = FILL_W'(r_count + 1'b1);
                end
                n_state = ST_IDLE;
            end
            ST_POP: begin
                n_done        = 1'b1;
                n_pop_valid   = 1'b1;
                n_pop_handle  = HANDLE_W'(r_rd_data.handle);
                n_evicted     = 1'b0;
                n_drop_report = '0;
                n_head        = wrap((CW + 1)'(r_head) + (CW + 1)'(1));
                n_count       = r_count - 1'b1;
                n_fill        = FILL_W'(r_count - 1'b1);
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_drop   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx      <= n_rd_idx;
        r_wr_idx      <= n_wr_idx;
        r_keyed       <= n_keyed;
        r_key         <= n_key;
        r_handle      <= n_handle;
        r_pop_valid   <= n_pop_valid;
        r_pop_handle  <= n_pop_handle;
        r_evicted     <= n_evicted;
        r_drop_report <= n_drop_report;
        r_fill        <= n_fill;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_done;
    assign o_pop_valid   = r_pop_valid;
    assign o_pop_handle  = r_pop_handle;
    assign o_evicted     = r_evicted;
    assign o_drop_report = r_drop_report;
    assign o_fill_level  = r_fill;

endmodule
